/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mkmc_pkg.sv */
// Package: shared types and constants of the multi-key match counter.
package mkmc_pkg;

  localparam int MAX_KEYS_DEF = 16;  // default key capacity
  localparam int KEY_SLOTS    = 16;  // slots addressable by the 4-bit slot field
  localparam int QUEUE_DEPTH  = 4;   // front-to-back queue depth

  localparam int SLOT_W  = 4;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 16;
  localparam int KCNT_W  = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [KCNT_W-1:0]  KCNT_RESET = 5'd16;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_ELEM = 1'b1
  } opcode_t;

  // Command classes passed from front to back.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,  // write a key
    CMD_COUNT = 2'd1,  // compare and count
    CMD_FLUSH = 2'd2   // compare, count, then read out and clear
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_out_t;

endpackage

/* rtl/mkmc_front.sv */
// Front end: accepts input words, drops out-of-range loads, classifies the rest.
module mkmc_front #(
  parameter int MAX_KEYS = mkmc_pkg::MAX_KEYS_DEF
) (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic [mkmc_pkg::SLOT_W-1:0]         key_slot,
  input  logic signed [mkmc_pkg::VALUE_W-1:0] value,
  input  logic                                last_element,
  input  logic                                q_full,
  output logic                                q_push,
  output mkmc_pkg::entry_t                    q_entry
);

  localparam int NumSlots = (MAX_KEYS < mkmc_pkg::KEY_SLOTS) ? MAX_KEYS : mkmc_pkg::KEY_SLOTS;

  logic keep;

  assign in_ready = !q_full;

  always_comb begin
    q_entry.slot  = key_slot;
    q_entry.value = $unsigned(value);
    q_entry.cmd   = mkmc_pkg::CMD_LOAD;
    keep          = 1'b1;
    if (opcode == mkmc_pkg::OP_LOAD) begin
      // loads past the key store are ignored
      keep = ({1'b0, key_slot} < mkmc_pkg::KCNT_W'(NumSlots));
    end else if (last_element) begin
      q_entry.cmd = mkmc_pkg::CMD_FLUSH;
    end else begin
      q_entry.cmd = mkmc_pkg::CMD_COUNT;
    end
  end

  assign q_push = in_valid && in_ready && keep;

endmodule

/* rtl/mkmc_queue.sv */
// Small FIFO between front and back ends.
`include "assert_macros.svh"
module mkmc_queue #(
  parameter int DEPTH = mkmc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mkmc_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             pop,
  output mkmc_pkg::q_out_t q_out
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  mkmc_pkg::entry_t  mem [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   cnt;
  logic              do_push;
  logic              do_pop;

  assign full        = (cnt == CntW'(DEPTH));
  assign do_push     = push && !full;
  assign do_pop      = pop && (cnt != '0);
  assign q_out.valid = (cnt != '0);
  assign q_out.entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst, cnt <= CntW'(DEPTH), "queue count over depth")
  `ASSERT_NEXT(a_push_lands, clk, rst, do_push && !do_pop, cnt == $past(cnt) + 1'b1, "push lost")

endmodule

/* rtl/mkmc_back.sv */
// Back end: key and count stores, parallel compare, readout sequencer, output register.
`include "assert_macros.svh"
module mkmc_back #(
  parameter int MAX_KEYS = mkmc_pkg::MAX_KEYS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mkmc_pkg::KCNT_W-1:0]         cfg_wdata,
  input  mkmc_pkg::q_out_t                    q_out,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mkmc_pkg::SLOT_W-1:0]         key_index,
  output logic [mkmc_pkg::COUNT_W-1:0]        match_count,
  output logic                                last_count
);

  localparam int NumSlots = (MAX_KEYS < mkmc_pkg::KEY_SLOTS) ? MAX_KEYS : mkmc_pkg::KEY_SLOTS;
  localparam int IdxW     = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int KW       = mkmc_pkg::KCNT_W;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [KW-1:0]                   key_count;
  logic [mkmc_pkg::VALUE_W-1:0]    keys [NumSlots];
  logic [mkmc_pkg::COUNT_W-1:0]    counts [NumSlots];
  logic [mkmc_pkg::COUNT_W-1:0]    counts_next [NumSlots];
  logic [IdxW-1:0]                 idx;
  logic [IdxW-1:0]                 idx_next;
  logic [KW-1:0]                   n_use;
  logic                            idx_last;
  logic                            drain_load;
  logic                            is_cmp;
  logic                            clear_all;
  logic                            any_count;

  // keys in use, clipped to the store size
  assign n_use = (key_count > KW'(NumSlots)) ? KW'(NumSlots) : key_count;

  assign q_pop      = (state == ST_RUN) && q_out.valid;
  assign is_cmp     = q_pop && (q_out.entry.cmd != mkmc_pkg::CMD_LOAD);
  assign idx_last   = (KW'(idx) + KW'(1)) == n_use;
  assign drain_load = (state == ST_DRAIN) && (!out_valid || out_ready);
  assign clear_all  = (drain_load && idx_last) ||
                      (q_pop && (q_out.entry.cmd == mkmc_pkg::CMD_FLUSH) && (n_use == '0));

  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      counts_next[i] = counts[i];
      if (is_cmp && (KW'(i) < n_use) && (keys[i] == q_out.entry.value) &&
          (counts[i] != mkmc_pkg::COUNT_MAX)) begin
        counts_next[i] = counts[i] + 1'b1;
      end
      if (clear_all) begin
        counts_next[i] = '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      ST_RUN: begin
        if (q_pop && (q_out.entry.cmd == mkmc_pkg::CMD_FLUSH) && (n_use != '0)) begin
          state_next = ST_DRAIN;
          idx_next   = '0;
        end
      end
      ST_DRAIN: begin
        if (drain_load) begin
          if (idx_last) begin
            state_next = ST_RUN;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_out.entry.cmd == mkmc_pkg::CMD_LOAD)) begin
      keys[q_out.entry.slot[IdxW-1:0]] <= q_out.entry.value;
    end
    if (drain_load) begin
      key_index   <= mkmc_pkg::SLOT_W'(idx);
      match_count <= counts[idx];
      last_count  <= idx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      idx       <= '0;
      key_count <= mkmc_pkg::KCNT_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
        counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cfg_we) begin
        key_count <= cfg_wdata;
      end
      if (drain_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      for (int i = 0; i < NumSlots; i++) begin
        counts[i] <= counts_next[i];
      end
    end
  end

  always_comb begin
    any_count = 1'b0;
    for (int i = 0; i < NumSlots; i++) begin
      any_count = any_count | (counts[i] != '0);
    end
  end

  `ASSERT_IMPL(a_idx_in_range, clk, rst, state == ST_DRAIN, KW'(idx) < n_use, "readout index past keys in use")
  `ASSERT_NEXT(a_clear_after_last, clk, rst, drain_load && idx_last, !any_count, "counts not cleared after readout")

endmodule

/* rtl/multi_key_match_counter.sv */
// Top level: multi-key match counter (front classifier, queue, count/readout back end).
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | opcode, key_slot, value, last_element
//  result   | out_valid / out_ready| key_index, match_count, last_count
//  config   | cfg_we (no wait)     | cfg_wdata = key_count
//
// Loads and elements retire one word per cycle outside readout; the compare against all
//   keys and the saturating increments happen in parallel in the single back-end stage.
// A last element with n keys in use holds the back end while its n results are read out,
//   one result per cycle while out_ready is high; the 4-entry queue takes input until full.
// Reset clears the counts (flip-flops) and sets key_count to 16; no sweep.
// A stalled result sits in the output register; the back end waits only during readout.
module multi_key_match_counter #(
  parameter int MAX_KEYS    = mkmc_pkg::MAX_KEYS_DEF,
  parameter int QUEUE_DEPTH = mkmc_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [mkmc_pkg::KCNT_W-1:0]         cfg_wdata,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic [mkmc_pkg::SLOT_W-1:0]         key_slot,
  input  logic signed [mkmc_pkg::VALUE_W-1:0] value,
  input  logic                                last_element,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mkmc_pkg::SLOT_W-1:0]         key_index,
  output logic [mkmc_pkg::COUNT_W-1:0]        match_count,
  output logic                                last_count
);

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  mkmc_pkg::entry_t q_entry;
  mkmc_pkg::q_out_t q_out;

  // front: classify, drop loads beyond the key store
  mkmc_front #(
    .MAX_KEYS (MAX_KEYS)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .key_slot     (key_slot),
    .value        (value),
    .last_element (last_element),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  // decoupling queue
  mkmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_entry),
    .full     (q_full),
    .pop      (q_pop),
    .q_out    (q_out)
  );

  // back: key store, counts, readout
  mkmc_back #(
    .MAX_KEYS (MAX_KEYS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_out       (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_index   (key_index),
    .match_count (match_count),
    .last_count  (last_count)
  );

endmodule

/* tb/sv/multi_key_match_counter_tb.sv */
// Testbench for multi_key_match_counter: directed and random words, self-checking reports.
module multi_key_match_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Largest value the 5-bit key_count register takes; anything above KEY_SLOTS clips.
  localparam logic [mkmc_pkg::KCNT_W-1:0] KC_TOP = '1;
  // Register value that puts every slot in use.
  localparam logic [mkmc_pkg::KCNT_W-1:0] KC_ALL = mkmc_pkg::KCNT_W'(mkmc_pkg::KEY_SLOTS);
  // Highest slot of the key store.
  localparam logic [mkmc_pkg::SLOT_W-1:0] TOP_SLOT = mkmc_pkg::SLOT_W'(mkmc_pkg::KEY_SLOTS - 1);
  localparam int RANDOM_WORDS  = 236;
  // Queue plus back end, with margin: quiet time before a register write and at the end.
  localparam int DRAIN_CYCLES  = 24;
  localparam int CYCLE_LIMIT   = 1000000;

  // One count report as it leaves the result port.
  typedef struct packed {
    logic [mkmc_pkg::SLOT_W-1:0]  idx;
    logic [mkmc_pkg::COUNT_W-1:0] cnt;
    logic                         last;
  } count_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                cfg_we       = 1'b0;
  logic [mkmc_pkg::KCNT_W-1:0]         cfg_wdata    = '0;
  logic                                in_valid     = 1'b0;
  logic                                in_ready;
  logic                                opcode       = 1'b0;
  logic [mkmc_pkg::SLOT_W-1:0]         key_slot     = '0;
  logic signed [mkmc_pkg::VALUE_W-1:0] value        = '0;
  logic                                last_element = 1'b0;
  logic                                out_valid;
  logic                                out_ready    = 1'b0;
  logic [mkmc_pkg::SLOT_W-1:0]         key_index;
  logic [mkmc_pkg::COUNT_W-1:0]        match_count;
  logic                                last_count;

  // Mirror of the block: key store, per-slot tallies and the key_count register.
  logic signed [mkmc_pkg::VALUE_W-1:0] key_mirror [mkmc_pkg::KEY_SLOTS];
  logic [mkmc_pkg::COUNT_W-1:0]        tally      [mkmc_pkg::KEY_SLOTS];
  logic [mkmc_pkg::KCNT_W-1:0]         keys_active = mkmc_pkg::KCNT_RESET;

  count_report_t expected_reports [$];

  int errors      = 0;
  int cycles      = 0;
  int stall_left  = 0;
  bit in_gaps     = 1'b1;   // random gaps between input words
  bit stalls_on   = 1'b1;   // random back-pressure on the result port

  multi_key_match_counter uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .key_slot     (key_slot),
    .value        (value),
    .last_element (last_element),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .key_index    (key_index),
    .match_count  (match_count),
    .last_count   (last_count)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Mostly no gap, some short ones, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result-side back-pressure; at most one assignment to out_ready per edge.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Predict the effect of one accepted word: a load writes a key, an element
  // bumps every matching slot in use (saturating), a last element reads out
  // the slots in use in order and then clears all tallies.
  function automatic void tally_word(input mkmc_pkg::opcode_t op,
                                     input logic [mkmc_pkg::SLOT_W-1:0] slot,
                                     input logic signed [mkmc_pkg::VALUE_W-1:0] val,
                                     input logic last);
    int n;
    count_report_t r;
    if (op == mkmc_pkg::OP_LOAD) begin
      key_mirror[slot] = val;   // slot field never exceeds the store here
      return;
    end
    n = (keys_active > mkmc_pkg::MAX_KEYS_DEF) ? mkmc_pkg::MAX_KEYS_DEF : int'(keys_active);
    for (int i = 0; i < n; i++) begin
      if (key_mirror[i] == val && tally[i] != mkmc_pkg::COUNT_MAX) tally[i] = tally[i] + 1'b1;
    end
    if (last) begin
      for (int i = 0; i < n; i++) begin
        r.idx  = mkmc_pkg::SLOT_W'(i);
        r.cnt  = tally[i];
        r.last = (i == n - 1);
        expected_reports.push_back(r);
      end
      for (int i = 0; i < mkmc_pkg::KEY_SLOTS; i++) tally[i] = '0;
    end
  endfunction

  // Compare every accepted report with the oldest prediction.
  always @(posedge clk) begin
    count_report_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report index %0d count %0d last %0b",
                 $time, key_index, match_count, last_count);
      end else begin
        e = expected_reports.pop_front();
        if (key_index !== e.idx || match_count !== e.cnt || last_count !== e.last) begin
          errors++;
          $display("%0t: report mismatch: expected index %0d count %0d last %0b,",
                   $time, e.idx, e.cnt, e.last);
          $display("%0t:   got index %0d count %0d last %0b",
                   $time, key_index, match_count, last_count);
        end
      end
    end
  end

  // Present one word and hold it until taken. in_valid stays high on return so
  // back-to-back words never lower and raise it within one step.
  task automatic send_word(input mkmc_pkg::opcode_t op, input logic [mkmc_pkg::SLOT_W-1:0] slot,
                           input logic signed [mkmc_pkg::VALUE_W-1:0] val, input logic last);
    int gap;
    gap = in_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    key_slot     <= slot;
    value        <= val;
    last_element <= last;
    do @(posedge clk); while (!in_ready);
    tally_word(op, slot, val, last);
  endtask

  // Let the block go quiet: all reports in, queued non-reporting words retired.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_count(input logic [mkmc_pkg::KCNT_W-1:0] kc);
    cfg_we    <= 1'b1;
    cfg_wdata <= kc;
    @(posedge clk);
    keys_active = kc;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Extremes, zero, one clipped value and a fair share of the normal range.
  function automatic logic [mkmc_pkg::KCNT_W-1:0] random_key_count();
    unique case ($urandom_range(0, 7))
      0: return '0;
      1: return mkmc_pkg::KCNT_W'(1);
      2: return KC_ALL;
      3: return mkmc_pkg::KCNT_W'($urandom_range(mkmc_pkg::KEY_SLOTS + 1, KC_TOP));
      default: return mkmc_pkg::KCNT_W'($urandom_range(1, mkmc_pkg::KEY_SLOTS));
    endcase
  endfunction

  // Fill every slot before any element so no compare ever sees an unwritten key.
  // Slot 3 duplicates slot 2, and its load carries the last flag, which must be ignored.
  task automatic test_key_loads();
    send_word(mkmc_pkg::OP_LOAD, 0, 32'sh8000_0000, 1'b0);
    send_word(mkmc_pkg::OP_LOAD, 1, 32'sh0000_0000, 1'b0);
    send_word(mkmc_pkg::OP_LOAD, 2, -32'sd1, 1'b0);
    send_word(mkmc_pkg::OP_LOAD, 3, -32'sd1, 1'b1);
    for (int i = 4; i < mkmc_pkg::KEY_SLOTS - 1; i++) begin
      send_word(mkmc_pkg::OP_LOAD, mkmc_pkg::SLOT_W'(i), 32'sh0101_0101 * i, 1'b0);
    end
    send_word(mkmc_pkg::OP_LOAD, TOP_SLOT, 32'sh7fff_ffff, 1'b0);
  endtask

  // Field extremes as elements, a duplicate key pair, a miss, then readout of all 16.
  task automatic test_directed_counts();
    send_word(mkmc_pkg::OP_ELEM, 0, 32'sh8000_0000, 1'b0);
    send_word(mkmc_pkg::OP_ELEM, TOP_SLOT, 32'sh7fff_ffff, 1'b0);
    send_word(mkmc_pkg::OP_ELEM, 0, 32'sh0000_0000, 1'b0);
    send_word(mkmc_pkg::OP_ELEM, 5, -32'sd1, 1'b0);
    send_word(mkmc_pkg::OP_ELEM, 0, -32'sd1, 1'b0);
    send_word(mkmc_pkg::OP_ELEM, 9, 32'sd12345, 1'b0);
    // the last element itself is counted before readout
    send_word(mkmc_pkg::OP_ELEM, 0, 32'sh7fff_ffff, 1'b1);
  endtask

  task automatic test_key_count_settings();
    // single key: slot 1 is out of use and must not show up
    settle();
    write_key_count(1);
    send_word(mkmc_pkg::OP_ELEM, 0, key_mirror[0], 1'b0);
    send_word(mkmc_pkg::OP_ELEM, 0, key_mirror[1], 1'b0);
    send_word(mkmc_pkg::OP_ELEM, 0, key_mirror[0], 1'b1);
    // no key in use: nothing matches, readout is empty
    settle();
    write_key_count(0);
    send_word(mkmc_pkg::OP_ELEM, 0, key_mirror[0], 1'b0);
    send_word(mkmc_pkg::OP_ELEM, 0, key_mirror[2], 1'b1);
    // register above the slot count clips to 16
    settle();
    write_key_count(KC_TOP);
    send_word(mkmc_pkg::OP_ELEM, 0, key_mirror[TOP_SLOT], 1'b0);
    send_word(mkmc_pkg::OP_ELEM, 0, key_mirror[4], 1'b1);
    // shrink mid-run: slot 2/3 counts carry over, slot 10 is dropped and cleared
    settle();
    write_key_count(KC_ALL);
    send_word(mkmc_pkg::OP_ELEM, 0, key_mirror[2], 1'b0);
    send_word(mkmc_pkg::OP_ELEM, 0, key_mirror[10], 1'b0);
    settle();
    write_key_count(4);
    send_word(mkmc_pkg::OP_ELEM, 0, key_mirror[2], 1'b1);
    // widen again: slot 10 must read back as zero
    settle();
    write_key_count(12);
    send_word(mkmc_pkg::OP_ELEM, 0, key_mirror[1], 1'b1);
    settle();
    write_key_count(KC_ALL);
  endtask

  // Bursts of elements ending mostly in a last flag, with key reloads mixed in
  // (random content or copies to make duplicates) and register changes between bursts.
  task automatic test_random_traffic();
    int sent;
    int burst;
    logic signed [mkmc_pkg::VALUE_W-1:0] v;
    logic [mkmc_pkg::SLOT_W-1:0]         s;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        write_key_count(random_key_count());
      end
      in_gaps   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst; i++) begin
        s = mkmc_pkg::SLOT_W'($urandom_range(0, mkmc_pkg::KEY_SLOTS - 1));
        if ($urandom_range(0, 6) == 0) begin
          v = ($urandom_range(0, 1) != 0) ? $urandom() : key_mirror[s];
          send_word(mkmc_pkg::OP_LOAD, mkmc_pkg::SLOT_W'($urandom_range(0, mkmc_pkg::KEY_SLOTS - 1)),
                    v, 1'($urandom_range(0, 1)));
        end else begin
          v = ($urandom_range(0, 3) != 0) ? key_mirror[s] : $urandom();
          send_word(mkmc_pkg::OP_ELEM, mkmc_pkg::SLOT_W'($urandom_range(0, mkmc_pkg::KEY_SLOTS - 1)),
                    v, (i == burst - 1) && ($urandom_range(0, 4) != 0));
        end
        sent++;
      end
    end
    in_gaps   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < mkmc_pkg::KEY_SLOTS; i++) begin
      key_mirror[i] = '0;
      tally[i]      = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_key_loads();
    test_directed_counts();
    test_key_count_settings();
    test_random_traffic();
    settle();

    if (errors == 0 && expected_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
